// ===== hdl/mts_pkg.sv =====
// Shared types and constants for the melody tone sequencer.
// No dependencies; imported by mts_div, the core and the testbench.
package mts_pkg;

    // Table depth default and the width used for position/length compares
    localparam int TABLE_DEPTH_DEF = 128;
    localparam int CMP_W           = 11;

    // Field widths
    localparam int RATE_W   = 24;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int INDEX_W  = 7;
    localparam int PERIOD_W = 24;
    localparam int DUTY_W   = 23;
    localparam int POS_W    = 8;
    localparam int ENTRY_W  = FREQ_W + DUR_W;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [RATE_W-1:0] TICK_RATE_RST = 24'd1000000;
    localparam logic [POS_W-1:0]  SONG_LEN_RST  = 8'd0;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_TICK_RATE   = 1'b0,
        REG_SONG_LENGTH = 1'b1
    } cfg_reg_t;

    // Input item kind, carried on s_tuser
    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } item_mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_FETCH,
        ST_LOAD,
        ST_DIVIDE,
        ST_COUNT,
        ST_EMIT
    } seq_state_t;

endpackage

// ===== hdl/mts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mts_div.sv =====
// Bit-serial restoring divider: 24-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Depends on mts_pkg.
module mts_div
    import mts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [RATE_W-1:0]   dividend,
    input  logic [FREQ_W-1:0]   divisor,
    output logic                busy,
    output logic                done,
    output logic [RATE_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(RATE_W + 1);

    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [FREQ_W:0]   trial;
    logic [FREQ_W:0]   diff;
    logic              ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign trial = {rem_reg, quo_reg[RATE_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(RATE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[RATE_W-2:0], ge};
            rem_next = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    // Quotient is only reported at the end of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a preceding run");
    // A new run is never started on top of one in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    // Iteration count stays within the dividend width
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(RATE_W)))
        else $error("divider count out of range");
`endif

endmodule

// ===== hdl/melody_tone_sequencer_core.sv =====
// Path: a load beat passes the apply and emit states to the result register, and a tick
// without a note fetch the apply, count and emit states; a tick that fetches a note also passes
// fetch (RAM read), load and the 24-step bit-serial period divider before count and emit.
// Flow: one beat in work at a time; the next beat is taken while a result waits in the output
// register, and a full output register holds the block. Reset: aresetn synchronous, active low;
// clears control state and configuration registers, not the payload registers or the table.
module melody_tone_sequencer_core
    import mts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] pause_button, [1] play_button, [8:2] entry_index,
    // [24:9] entry_frequency, [40:25] entry_duration, [47:41] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [0] mode
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [23:0] tone_period, [46:24] tone_duty, [47] is_playing, [55:48] position
    output logic [M_DATA_W-1:0]   m_tdata,
    // song_finished
    output logic                  m_tlast,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    // Configuration registers
    logic [RATE_W-1:0] tick_rate_reg;
    logic [POS_W-1:0]  song_len_reg;
    logic              cfg_wr;

    // Sequencer state
    seq_state_t          state_reg, state_next;
    logic                pause_seen_reg, pause_seen_next;
    logic                play_seen_reg, play_seen_next;
    logic                playing_reg, playing_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [DUR_W-1:0]    ms_left_reg, ms_left_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                fin_reg, fin_next;
    logic                fzero_reg, fzero_next;

    // Captured input beat
    item_mode_t         mode_reg;
    logic               pause_in_reg, play_in_reg;
    logic [INDEX_W-1:0] index_in_reg;
    logic [FREQ_W-1:0]  freq_in_reg;
    logic [DUR_W-1:0]   dur_in_reg;

    // Output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    // Button step intermediates
    logic                b_playing;
    logic [POS_W-1:0]    b_pos;
    logic [DUR_W-1:0]    b_ms;
    logic [DUTY_W-1:0]   b_duty;
    logic                need_fetch;
    logic [CMP_W-1:0]    song_len_ext;
    logic [CMP_W-1:0]    len;
    logic [DUR_W-1:0]    ms_dec;
    logic [POS_W-1:0]    pos_inc;
    logic [PERIOD_W-1:0] div_period;
    logic                out_free;

    // Control outputs
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [RATE_W-1:0]   div_quo;

    // APB: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= TICK_RATE_RST;
            song_len_reg  <= SONG_LEN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_TICK_RATE:   tick_rate_reg <= pwdata[RATE_W-1:0];
                REG_SONG_LENGTH: song_len_reg  <= pwdata[POS_W-1:0];
                default:         tick_rate_reg <= tick_rate_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_TICK_RATE:   prdata = {{(APB_DATA_W-RATE_W){1'b0}}, tick_rate_reg};
            REG_SONG_LENGTH: prdata = {{(APB_DATA_W-POS_W){1'b0}}, song_len_reg};
            default:         prdata = '0;
        endcase
    end

    // Song length clipped to the table depth
    assign song_len_ext = CMP_W'(song_len_reg);
    assign len          = (song_len_ext > DEPTH_C) ? DEPTH_C : song_len_ext;

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg     <= item_mode_t'(s_tuser);
            pause_in_reg <= s_tdata[0];
            play_in_reg  <= s_tdata[1];
            index_in_reg <= s_tdata[8:2];
            freq_in_reg  <= s_tdata[24:9];
            dur_in_reg   <= s_tdata[40:25];
        end
    end

    // Button edges: pause acts first, then play
    always_comb begin
        b_playing = playing_reg;
        b_duty    = duty_reg;
        b_pos     = pos_reg;
        b_ms      = ms_left_reg;
        if (!pause_in_reg && pause_seen_reg && playing_reg) begin
            b_playing = 1'b0;
            b_duty    = '0;
        end
        if (!play_in_reg && play_seen_reg) begin
            b_playing = 1'b1;
            if (CMP_W'(pos_reg) >= len) begin
                b_pos = '0;
                b_ms  = '0;
            end
            if ((b_ms != '0) && (period_reg != '0)) begin
                b_duty = period_reg[PERIOD_W-1:1];
            end
        end
        need_fetch = b_playing && (b_ms == '0) && (CMP_W'(b_pos) < len);
    end

    // Period from the divider: zero frequency saturates, floor of two
    always_comb begin
        div_period = fzero_reg ? tick_rate_reg : div_quo;
        if (div_period[PERIOD_W-1:1] == '0) begin
            div_period = PERIOD_W'(2);
        end
    end

    assign ms_dec   = ms_left_reg - DUR_W'(1);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_APPLY;
            ST_APPLY: begin
                if (mode_reg == MODE_LOAD) state_next = ST_EMIT;
                else if (need_fetch)       state_next = ST_FETCH;
                else                       state_next = ST_COUNT;
            end
            ST_FETCH:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_done) state_next = ST_COUNT;
            ST_COUNT:  state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_APPLY: ram_we = (mode_reg == MODE_LOAD) && (CMP_W'(index_in_reg) < DEPTH_C);
            ST_LOAD:  div_start = 1'b1;
            default:  s_tready = 1'b0;
        endcase
    end

    assign ram_waddr = ADDR_W'(index_in_reg);
    assign ram_raddr = ADDR_W'(pos_reg);

    // Sequencer datapath
    always_comb begin
        pause_seen_next = pause_seen_reg;
        play_seen_next  = play_seen_reg;
        playing_next    = playing_reg;
        pos_next        = pos_reg;
        ms_left_next    = ms_left_reg;
        period_next     = period_reg;
        duty_next       = duty_reg;
        fin_next        = fin_reg;
        fzero_next      = fzero_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        unique case (state_reg)
            ST_APPLY: begin
                fin_next = 1'b0;
                if (mode_reg == MODE_TICK) begin
                    pause_seen_next = pause_in_reg;
                    play_seen_next  = play_in_reg;
                    playing_next    = b_playing;
                    pos_next        = b_pos;
                    ms_left_next    = b_ms;
                    duty_next       = b_duty;
                end
            end
            ST_LOAD: begin
                ms_left_next = ram_rdata[DUR_W-1:0];
                fzero_next   = (ram_rdata[ENTRY_W-1:DUR_W] == '0);
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    period_next = div_period;
                    duty_next   = div_period[PERIOD_W-1:1];
                end
            end
            ST_COUNT: begin
                // Count the note down; step on and stop at the song end
                if (playing_reg && (ms_left_reg != '0)) begin
                    ms_left_next = ms_dec;
                    if (ms_dec == '0) begin
                        pos_next = pos_inc;
                        if (CMP_W'(pos_inc) >= len) begin
                            playing_next = 1'b0;
                            duty_next    = '0;
                            fin_next     = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pos_reg, playing_reg, duty_reg, period_reg};
                    m_tlast_next  = fin_reg;
                end
            end
            default: fin_next = fin_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pause_seen_reg <= 1'b0;
            play_seen_reg  <= 1'b0;
            playing_reg    <= 1'b0;
            pos_reg        <= '0;
            ms_left_reg    <= '0;
            period_reg     <= '0;
            duty_reg       <= '0;
            fin_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pause_seen_reg <= pause_seen_next;
            play_seen_reg  <= play_seen_next;
            playing_reg    <= playing_next;
            pos_reg        <= pos_next;
            ms_left_reg    <= ms_left_next;
            period_reg     <= period_next;
            duty_reg       <= duty_next;
            fin_reg        <= fin_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fzero_reg   <= fzero_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Note table: frequency in the upper half, duration in the lower
    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({freq_in_reg, dur_in_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Period divider
    mts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tick_rate_reg),
        .divisor  (ram_rdata[ENTRY_W-1:DUR_W]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

`ifndef ASSERT_OFF
    // A stopped song is always muted
    assert property (@(posedge aclk) disable iff (!aresetn)
        !playing_reg |-> (duty_reg == '0))
        else $error("duty non-zero while not playing");
    // The song-end beat never reports playing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> !m_tdata_reg[PERIOD_W+DUTY_W])
        else $error("finished beat reports playing");
    // Once a note is loaded the period is at least two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (period_reg != '0) |-> (period_reg >= PERIOD_W'(2)))
        else $error("period below two");
    // The divider is only waited on while it runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");
`endif

endmodule

// ===== test/melody_tone_sequencer_core_test.sv =====
// Self-checking testbench for melody_tone_sequencer_core: tick and load beats with
// random idling on both streams, a cycle-free tone predictor and register read-back.
// Depends on mts_pkg and the melody_tone_sequencer_core RTL.
module melody_tone_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
    localparam int ITEMS_TOTAL   = 1950;
    localparam int QUIET_TAIL    = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;

    // Result beat layout on m_tdata
    localparam int DUTY_LSB = PERIOD_W;
    localparam int PLAY_BIT = PERIOD_W + DUTY_W;
    localparam int POS_LSB  = PLAY_BIT + 1;

    typedef struct {
        item_mode_t         mode;
        logic               pause;
        logic               play;
        logic [INDEX_W-1:0] index;
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
    } note_cmd_t;

    typedef struct {
        logic [PERIOD_W-1:0] period;
        logic [DUTY_W-1:0]   duty;
        logic                playing;
        logic [POS_W-1:0]    position;
        logic                finished;
    } tone_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the registers and the sequencer state
    logic [RATE_W-1:0]   rate_hz    = TICK_RATE_RST;
    logic [POS_W-1:0]    song_len   = SONG_LEN_RST;
    logic                pause_held = 1'b0;
    logic                play_held  = 1'b0;
    logic                playing_p  = 1'b0;
    logic [POS_W-1:0]    note_pos   = '0;
    logic [DUR_W-1:0]    ms_left    = '0;
    logic [PERIOD_W-1:0] cur_period = '0;
    logic [DUTY_W-1:0]   cur_duty   = '0;
    logic [FREQ_W-1:0]   freq_tab [TABLE_DEPTH];
    logic [DUR_W-1:0]    dur_tab  [TABLE_DEPTH];

    tone_t tone_expect_q [$];

    int fail_count = 0;
    int beats_sent = 0;
    int tones_seen = 0;
    int songs_done = 0;
    int cfg_writes = 0;
    int stall_left = 0;
    bit idling     = 1'b1;
    bit hold_req   = 1'b0;

    melody_tone_sequencer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d result beats outstanding", $time, tone_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Timer period for a note: rate over frequency, saturated on zero, at least 2
    function automatic logic [PERIOD_W-1:0] period_for(logic [FREQ_W-1:0] f);
        logic [RATE_W-1:0] q;
        q = (f == '0) ? rate_hz : rate_hz / RATE_W'(f);
        return (q < 2) ? PERIOD_W'(2) : q;
    endfunction

    // Advance the sequencer copy by one accepted beat and queue the tone it reports
    task automatic predict_tone(note_cmd_t c);
        tone_t            t;
        logic [POS_W-1:0] eff_len;
        t.finished = 1'b0;
        eff_len = (song_len > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : song_len;
        if (c.mode == MODE_LOAD) begin
            freq_tab[c.index] = c.freq;
            dur_tab[c.index]  = c.dur;
        end else begin
            // Buttons act on release; pause is handled before play
            if (c.pause) begin
                pause_held = 1'b1;
            end else if (pause_held) begin
                pause_held = 1'b0;
                if (playing_p) begin
                    playing_p = 1'b0;
                    cur_duty  = '0;
                end
            end
            if (c.play) begin
                play_held = 1'b1;
            end else if (play_held) begin
                play_held = 1'b0;
                playing_p = 1'b1;
                if (note_pos >= eff_len) begin
                    note_pos = '0;
                    ms_left  = '0;
                end
                if (ms_left != 0 && cur_period != 0)
                    cur_duty = cur_period[PERIOD_W-1:1];
            end
            if (playing_p) begin
                // Fetch the next note once the current one has run out
                if (ms_left == 0 && note_pos < eff_len) begin
                    cur_period = period_for(freq_tab[INDEX_W'(note_pos)]);
                    cur_duty   = cur_period[PERIOD_W-1:1];
                    ms_left    = dur_tab[INDEX_W'(note_pos)];
                end
                if (ms_left != 0) begin
                    ms_left--;
                    if (ms_left == 0) begin
                        note_pos++;
                        if (note_pos >= eff_len) begin
                            playing_p  = 1'b0;
                            cur_duty   = '0;
                            t.finished = 1'b1;
                            songs_done++;
                        end
                    end
                end
            end
        end
        t.period   = cur_period;
        t.duty     = cur_duty;
        t.playing  = playing_p;
        t.position = note_pos;
        tone_expect_q.push_back(t);
    endtask

    // Offer one beat, optionally after an idle burst, and hold it until taken
    task automatic send_beat(note_cmd_t c);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.mode;
        s_tdata  <= S_DATA_W'({c.dur, c.freq, c.index, c.play, c.pause});
        do @(posedge aclk); while (!s_tready);
        predict_tone(c);
        beats_sent++;
    endtask

    // Tick beat: the unused entry fields carry junk that must be ignored
    task automatic tick(logic pause, logic play);
        note_cmd_t c;
        c.mode  = MODE_TICK;
        c.pause = pause;
        c.play  = play;
        c.index = INDEX_W'($urandom);
        c.freq  = FREQ_W'($urandom);
        c.dur   = DUR_W'($urandom);
        send_beat(c);
    endtask

    // Load beat: button levels carry junk that must be ignored
    task automatic load_entry(logic [INDEX_W-1:0] idx, logic [FREQ_W-1:0] f,
                              logic [DUR_W-1:0] d);
        note_cmd_t c;
        c.mode  = MODE_LOAD;
        c.pause = 1'($urandom_range(0, 1));
        c.play  = 1'($urandom_range(0, 1));
        c.index = idx;
        c.freq  = f;
        c.dur   = d;
        send_beat(c);
    endtask

    // Stop offering beats and wait for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tone_expect_q.size() != 0);
    endtask

    // Write a register while the block is idle, then read it back
    task automatic write_reg(cfg_reg_t r, logic [APB_DATA_W-1:0] v);
        logic [APB_DATA_W-1:0] want;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (r == REG_TICK_RATE) begin
            rate_hz = v[RATE_W-1:0];
            want    = APB_DATA_W'(rate_hz);
        end else begin
            song_len = v[POS_W-1:0];
            want     = APB_DATA_W'(song_len);
        end
        cfg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Check each result beat against the oldest prediction and drive m_tready
    always @(posedge aclk) begin
        tone_t want;
        if (aresetn && m_tvalid && m_tready) begin
            tones_seen++;
            if (tone_expect_q.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, actual %h/%b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = tone_expect_q.pop_front();
                check_field("tone_period", 32'(want.period), 32'(m_tdata[PERIOD_W-1:0]));
                check_field("tone_duty", 32'(want.duty), 32'(m_tdata[PLAY_BIT-1:DUTY_LSB]));
                check_field("is_playing", 32'(want.playing), 32'(m_tdata[PLAY_BIT]));
                check_field("position", 32'(want.position),
                            32'(m_tdata[POS_LSB+POS_W-1:POS_LSB]));
                check_field("song_finished", 32'(want.finished), 32'(m_tlast));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Start, pause mid-note, resume with the duty restored, run to the end
    task automatic test_playback_controls();
        tick(0, 0);
        load_entry(0, 16'd440, 16'd4);
        load_entry(1, 16'd0, 16'd1);
        load_entry(2, 16'hFFFF, 16'd1);
        load_entry(7'd127, 16'hFFFF, 16'hFFFF);
        write_reg(REG_SONG_LENGTH, 3);
        tick(0, 1);
        tick(0, 0);
        tick(1, 0);
        tick(0, 0);
        tick(0, 1);
        tick(0, 0);
        repeat (3) tick(0, 0);
    endtask

    // Rate extremes, both buttons at once, length cut below the position, empty song
    task automatic test_register_extremes();
        write_reg(REG_TICK_RATE, 2);
        tick(1, 1);
        tick(0, 0);
        write_reg(REG_TICK_RATE, 24'hFFFFFF);
        write_reg(REG_SONG_LENGTH, 0);
        repeat (4) tick(0, 0);
        tick(0, 1);
        tick(0, 0);
    endtask

    // A zero-length note is fetched again on every tick and never ends
    task automatic test_zero_duration();
        load_entry(0, 16'd0, 16'd0);
        write_reg(REG_SONG_LENGTH, 1);
        repeat (3) tick(0, 0);
        tick(1, 0);
        tick(0, 0);
    endtask

    // Fill the whole table with short notes and play it at full and oversized length
    task automatic test_full_table_song();
        int guard;
        write_reg(REG_TICK_RATE, APB_DATA_W'(TICK_RATE_RST));
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(INDEX_W'(i), FREQ_W'($urandom), DUR_W'($urandom_range(1, 2)));
        for (int pass = 0; pass < 2; pass++) begin
            write_reg(REG_SONG_LENGTH, (pass == 0) ? 128 : 200);
            if (pass == 1)
                write_reg(REG_TICK_RATE, $urandom_range(2, 24'hFFFFFF));
            tick(0, 1);
            tick(0, 0);
            guard = 0;
            while (playing_p && guard < 1000) begin
                tick(0, 0);
                guard++;
            end
        end
    endtask

    // Hold the result side off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        write_reg(REG_SONG_LENGTH, 8);
        tick(0, 1);
        tick(0, 0);
        hold_req = 1'b1;
        repeat (16) tick(0, 0);
        wait_drained();
    endtask

    // Episodes of button play with random settings, loads and noise
    task automatic test_random_songs();
        int unsigned        pick;
        logic [RATE_W-1:0]  rate;
        logic [INDEX_W-1:0] idx;
        logic [FREQ_W-1:0]  f;
        logic [DUR_W-1:0]   d;
        while (beats_sent < ITEMS_TOTAL) begin
            if (beats_sent >= ITEMS_TOTAL - QUIET_TAIL)
                idling = 1'b0;
            else
                idling = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 4))
                    0:       rate = TICK_RATE_RST;
                    1:       rate = 2;
                    2:       rate = 24'hFFFFFF;
                    3:       rate = RATE_W'($urandom_range(2, 300));
                    default: rate = RATE_W'($urandom_range(2, 24'hFFFFFF));
                endcase
                write_reg(REG_TICK_RATE, APB_DATA_W'(rate));
            end
            // Lengths stay clear of the top entries, which may hold very long notes
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_SONG_LENGTH, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(13, 119) : $urandom_range(0, 12));
            tick(0, 1);
            tick(0, 0);
            repeat ($urandom_range(20, 60)) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    tick(0, 0);
                end else if (pick < 65) begin
                    idx = ($urandom_range(0, 3) != 0) ? INDEX_W'($urandom_range(0, 15))
                                                      : INDEX_W'($urandom_range(0, 119));
                    d   = ($urandom_range(0, 15) == 0) ? 16'd0 : DUR_W'($urandom_range(1, 4));
                    f   = ($urandom_range(0, 15) == 0) ? 16'd0 : FREQ_W'($urandom);
                    if ($urandom_range(0, 19) == 0) begin
                        idx = INDEX_W'($urandom_range(120, 127));
                        d   = DUR_W'($urandom);
                    end
                    load_entry(idx, f, d);
                end else if (pick < 73) begin
                    repeat ($urandom_range(1, 4)) tick(1, 0);
                    tick(0, 0);
                end else if (pick < 81) begin
                    repeat ($urandom_range(1, 4)) tick(0, 1);
                    tick(0, 0);
                end else if (pick < 85) begin
                    tick(1, 1);
                    tick(0, 0);
                end else begin
                    tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        int drain_wait;
        drain_wait = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_playback_controls();
        test_register_extremes();
        test_zero_duration();
        test_full_table_song();
        test_output_backpressure();
        test_random_songs();

        // Drain, then allow a full fetch latency for any stray beat
        s_tvalid <= 1'b0;
        while (tone_expect_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        if (tone_expect_q.size() != 0) begin
            $display("%0t: %0d result beats expected, 0 arrived", $time, tone_expect_q.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d tick/load beats, checked %0d tone beats, %0d register writes,",
                 beats_sent, tones_seen, cfg_writes);
        $display("%0d songs ran to their last note; %0d mismatches.", songs_done, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/mts_div.sv
hdl/melody_tone_sequencer_core.sv
test/melody_tone_sequencer_core_test.sv
